@@ design/tdz_pkg.sv @@
// Shared constants and types for the thumbstick radial dead zone pipeline.
package tdz_pkg;

  localparam int unsigned FULL_SCALE   = 32767;
  localparam int unsigned RADIUS_RESET = 7849;
  localparam int unsigned SQRT_STAGES  = 16;
  localparam int unsigned DIV_STAGES   = 16;

  // Sideband that travels beside the square root.
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic        nx;
    logic        ny;
    logic        dz;
    logic [14:0] d;
  } side_sqrt_t;

  // Sideband that travels beside the dividers.
  typedef struct packed {
    logic nx;
    logic ny;
    logic dz;
  } side_div_t;

endpackage

@@ design/thumbstick_radial_deadzone.sv @@
// Pipeline: 37 register stages from the accepted sample to the output register.
// Throughput: one sample per cycle; the whole pipeline advances together when the
// output register is empty or its transaction completes, so a stall holds every stage.
// Depth is set by the 16-stage square root and the 16-stage dividers.
// Reset clears all valid bits and loads the dead zone radius with 7849.
module thumbstick_radial_deadzone
  import tdz_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic               in_deadzone
);

  localparam int unsigned LAT = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1;

  logic            en;
  logic [14:0]     deadzone_radius;
  logic [LAT-1:0]  vld;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_radius <= 15'(RADIUS_RESET);
    end else if (cfg_we) begin
      deadzone_radius <= cfg_data;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage A: magnitudes and signs.
  logic [15:0] a_ax, a_ay;
  logic        a_nx, a_ny;
  logic [14:0] a_d;
  always_ff @(posedge clk) begin
    if (en) begin
      a_ax <= stick_x[15] ? 16'(-stick_x) : stick_x;
      a_ay <= stick_y[15] ? 16'(-stick_y) : stick_y;
      a_nx <= stick_x[15];
      a_ny <= stick_y[15];
      a_d  <= deadzone_radius;
    end
  end

  // Stage B: squares.
  logic [30:0] b_sx, b_sy;
  logic [29:0] b_dd;
  logic [15:0] b_ax, b_ay;
  logic        b_nx, b_ny;
  logic [14:0] b_d;
  always_ff @(posedge clk) begin
    if (en) begin
      b_sx <= 31'(a_ax * a_ax);
      b_sy <= 31'(a_ay * a_ay);
      b_dd <= 30'(a_d * a_d);
      b_ax <= a_ax;
      b_ay <= a_ay;
      b_nx <= a_nx;
      b_ny <= a_ny;
      b_d  <= a_d;
    end
  end

  // Stage C: squared radius and the dead zone test.
  logic [31:0] sum_c;
  logic [31:0] c_s;
  side_sqrt_t  c_side;
  assign sum_c = {1'b0, b_sx} + {1'b0, b_sy};
  always_ff @(posedge clk) begin
    if (en) begin
      c_s       <= sum_c;
      c_side.ax <= b_ax;
      c_side.ay <= b_ay;
      c_side.nx <= b_nx;
      c_side.ny <= b_ny;
      c_side.dz <= sum_c <= {2'b00, b_dd};
      c_side.d  <= b_d;
    end
  end

  // Square root with its sideband delay line.
  logic [15:0] root;
  side_sqrt_t  sq_side [SQRT_STAGES];

  tdz_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .s    (c_s),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= c_side;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sq_side[i] <= sq_side[i-1];
      end
    end
  end

  // Stage M: rescale ratio terms and the products for both dividers.
  side_sqrt_t  ms;
  logic [14:0] clamp_m, num_m, den_m, num_f, den_f;
  assign ms      = sq_side[SQRT_STAGES-1];
  assign clamp_m = (root > 16'(FULL_SCALE)) ? 15'(FULL_SCALE) : root[14:0];
  assign num_m   = (clamp_m > ms.d) ? 15'(clamp_m - ms.d) : 15'd0;
  assign den_m   = 15'(15'(FULL_SCALE) - ms.d);

  always_comb begin
    if (den_m == '0) begin
      num_f = 15'd1;
      den_f = 15'd1;
    end else if (num_m > den_m) begin
      num_f = den_m;
      den_f = den_m;
    end else begin
      num_f = num_m;
      den_f = den_m;
    end
  end

  logic [30:0] m_px, m_py, m_pd;
  side_div_t   m_side;
  always_ff @(posedge clk) begin
    if (en) begin
      m_px      <= 31'(ms.ax * num_f);
      m_py      <= 31'(ms.ay * num_f);
      m_pd      <= 31'(root * den_f);
      m_side.nx <= ms.nx;
      m_side.ny <= ms.ny;
      m_side.dz <= ms.dz;
    end
  end

  // Dividers with their sideband delay line.
  logic [15:0] qx, qy;
  side_div_t   dv_side [DIV_STAGES];

  tdz_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (m_px),
    .den (m_pd),
    .quo (qx)
  );

  tdz_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (m_py),
    .den (m_pd),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= m_side;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dv_side[i] <= dv_side[i-1];
      end
    end
  end

  // Output stage: saturation, sign and dead zone override.
  side_div_t   os;
  logic [15:0] sx, sy;
  assign os = dv_side[DIV_STAGES-1];

  always_comb begin
    if (os.nx) begin
      sx = 16'(-((qx > 16'h8000) ? 16'h8000 : qx));
    end else begin
      sx = (qx > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : qx;
    end
    if (os.ny) begin
      sy = 16'(-((qy > 16'h8000) ? 16'h8000 : qy));
    end else begin
      sy = (qy > 16'(FULL_SCALE)) ? 16'(FULL_SCALE) : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x       <= os.dz ? 16'sd0 : signed'(sx);
      out_y       <= os.dz ? 16'sd0 : signed'(sy);
      in_deadzone <= os.dz;
    end
  end

endmodule

@@ design/tdz_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
module tdz_sqrt
  import tdz_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] s,
  output logic [15:0] root
);

  logic [17:0] rem_q  [SQRT_STAGES];
  logic [15:0] root_q [SQRT_STAGES];
  logic [31:0] word_q [SQRT_STAGES];

  genvar k;
  generate
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [17:0] rem_in;
      logic [15:0] root_in;
      logic [31:0] word_in;
      logic [19:0] r2;
      logic [19:0] t;

      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign word_in = s;
      end else begin : g_next
        assign rem_in  = rem_q[k-1];
        assign root_in = root_q[k-1];
        assign word_in = word_q[k-1];
      end

      // Bring down the next two bits and try the next root bit.
      assign r2 = {rem_in, word_in[31:30]};
      assign t  = {2'b00, root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          word_q[k] <= {word_in[29:0], 2'b00};
          if (r2 >= t) begin
            rem_q[k]  <= 18'(r2 - t);
            root_q[k] <= {root_in[14:0], 1'b1};
          end else begin
            rem_q[k]  <= r2[17:0];
            root_q[k] <= {root_in[14:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root = root_q[SQRT_STAGES-1];

endmodule

@@ design/tdz_div.sv @@
// Pipelined restoring divider: 31-bit product shifted by 15 over a 31-bit divisor.
module tdz_div
  import tdz_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic [15:0] quo
);

  logic [45:0] rem_q [DIV_STAGES];
  logic [30:0] den_q [DIV_STAGES];
  logic [15:0] quo_q [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int unsigned SH = DIV_STAGES - 1 - k;
      logic [45:0] rem_in;
      logic [30:0] den_in;
      logic [15:0] quo_in;
      logic [45:0] trial;

      if (k == 0) begin : g_first
        assign rem_in = {num, 15'd0};
        assign den_in = den;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1];
        assign den_in = den_q[k-1];
        assign quo_in = quo_q[k-1];
      end

      // Divisor aligned to the quotient bit decided in this stage.
      assign trial = 46'({15'd0, den_in} << SH);

      always_ff @(posedge clk) begin
        if (en) begin
          den_q[k] <= den_in;
          if (rem_in >= trial) begin
            rem_q[k] <= rem_in - trial;
            quo_q[k] <= {quo_in[14:0], 1'b1};
          end else begin
            rem_q[k] <= rem_in;
            quo_q[k] <= {quo_in[14:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo = quo_q[DIV_STAGES-1];

endmodule
